### src/msgsp_pkg.sv
// Package for the multistage-graph shortest-path block.
// Holds the request and result structs, size constants, controller states
// and the command and status bundles shared by the controller and datapath.
`default_nettype none

package msgsp_pkg;

  localparam int MAX_STAGES     = 16;
  localparam int MAX_NODES      = 16;
  localparam int COST_WIDTH_DEF = 32;
  localparam int NODE_W         = 4;
  localparam int STAGE_W        = 4;
  localparam int CNT_W          = 5;
  localparam int EDGE_W         = 16;
  localparam int TOTAL_W        = 32;

  localparam logic [1:0] REQ_DECL  = 2'd0;
  localparam logic [1:0] REQ_EDGE  = 2'd1;
  localparam logic [1:0] REQ_SOLVE = 2'd2;

  typedef struct packed {
    logic [1:0]               req_type;
    logic [CNT_W-1:0]         node_count;
    logic [NODE_W-1:0]        from_node;
    logic [NODE_W-1:0]        to_node;
    logic signed [EDGE_W-1:0] edge_cost;
  } in_t;

  typedef struct packed {
    logic [STAGE_W-1:0]        stage_index;
    logic [NODE_W-1:0]         path_node;
    logic signed [TOTAL_W-1:0] total_cost;
    logic                      no_path;
    logic                      last;
  } out_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECL,
    S_RELAX,
    S_SCAN,
    S_PICK,
    S_BT_READ,
    S_BT_WAIT,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic load;
    logic decl;
    logic relax;
    logic scan;
    logic pick;
    logic bt_read;
    logic bt_write;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic scan_last;
    logic found;
    logic single;
    logic bt_last;
    logic emit_last;
    logic out_free;
  } stat_t;

endpackage

`default_nettype wire

### src/msgsp_ctrl.sv
// Controller state machine for the multistage-graph shortest-path block.
// Depends on msgsp_pkg; drives the datapath through cmd_t and reads stat_t.
`default_nettype none

module msgsp_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic [1:0]       in_req,
  output logic             in_ready,
  input  msgsp_pkg::stat_t stat,
  output msgsp_pkg::cmd_t  cmd
);
  import msgsp_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          unique case (in_req)
            REQ_DECL:  state_next = S_DECL;
            REQ_EDGE:  state_next = S_RELAX;
            REQ_SOLVE: state_next = S_SCAN;
            default:   state_next = S_IDLE;
          endcase
        end
      end
      S_DECL:  state_next = S_IDLE;
      S_RELAX: state_next = S_IDLE;
      S_SCAN: begin
        if (stat.scan_last) state_next = S_PICK;
      end
      S_PICK: begin
        if (!stat.found || stat.single) state_next = S_EMIT;
        else state_next = S_BT_READ;
      end
      S_BT_READ: state_next = S_BT_WAIT;
      S_BT_WAIT: begin
        if (stat.bt_last) state_next = S_EMIT;
        else state_next = S_BT_READ;
      end
      S_EMIT: begin
        if (stat.out_free && stat.emit_last) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      S_DECL:    cmd.decl     = 1'b1;
      S_RELAX:   cmd.relax    = 1'b1;
      S_SCAN:    cmd.scan     = 1'b1;
      S_PICK:    cmd.pick     = 1'b1;
      S_BT_READ: cmd.bt_read  = 1'b1;
      S_BT_WAIT: cmd.bt_write = 1'b1;
      S_EMIT:    cmd.emit     = stat.out_free;
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

`default_nettype wire

### src/msgsp_datapath.sv
// Datapath for the multistage-graph shortest-path block: cost and reached
// tables, edge relaxation, final-stage scan, parent RAM and output register.
// Depends on msgsp_pkg; controlled by msgsp_ctrl through cmd_t.
`default_nettype none

module msgsp_datapath #(
  parameter int COST_WIDTH = msgsp_pkg::COST_WIDTH_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  msgsp_pkg::in_t   in_data,
  input  msgsp_pkg::cmd_t  cmd,
  output msgsp_pkg::stat_t stat,
  output logic             out_valid,
  input  logic             out_ready,
  output msgsp_pkg::out_t  out_data
);
  import msgsp_pkg::*;

  localparam int CW = COST_WIDTH;
  localparam logic signed [CW-1:0] COST_MAX = {1'b0, {(CW-1){1'b1}}};
  localparam logic signed [CW-1:0] COST_MIN = {1'b1, {(CW-1){1'b0}}};

  in_t item;

  logic [CNT_W-1:0]        stage_total;
  logic [CNT_W-1:0]        prev_size;
  logic [CNT_W-1:0]        cur_size;
  logic [CNT_W-1:0]        sol_n;
  logic signed [CW-1:0]    prev_cost [MAX_NODES];
  logic signed [CW-1:0]    cur_cost  [MAX_NODES];
  logic [MAX_NODES-1:0]    prev_reached;
  logic [MAX_NODES-1:0]    cur_reached;
  logic [NODE_W-1:0]       cur_parent [MAX_NODES];
  logic [NODE_W-1:0]       parent_mem [MAX_STAGES*MAX_NODES];
  logic [NODE_W-1:0]       rd_data;
  logic [NODE_W-1:0]       path_buf [MAX_STAGES];

  logic [NODE_W-1:0]       sj;
  logic                    found;
  logic signed [CW-1:0]    best_cost;
  logic [NODE_W-1:0]       best_node;
  logic [NODE_W-1:0]       cur_node;
  logic [STAGE_W-1:0]      bs;
  logic [STAGE_W-1:0]      ej;

  logic [CNT_W-1:0]        n_sat;
  logic                    decl_ok;
  logic [NODE_W-1:0]       rd_idx;
  logic signed [CW-1:0]    cost_rd;
  logic signed [CW:0]      prev_ext;
  logic signed [CW:0]      ec_ext;
  logic signed [CW:0]      sum;
  logic signed [CW-1:0]    cand;
  logic                    edge_ok;
  logic                    relax_we;
  logic [STAGE_W-1:0]      cur_stage;
  logic                    scan_hit;
  logic                    emit_last;
  logic                    pw_we;
  logic [STAGE_W-1:0]      pw_idx;
  logic [NODE_W-1:0]       pw_data;

  always_comb begin
    n_sat   = (item.node_count > CNT_W'(MAX_NODES)) ? CNT_W'(MAX_NODES) : item.node_count;
    decl_ok = (item.node_count != '0) && (stage_total < CNT_W'(MAX_STAGES));

    // One read port on the current cost table, shared by relaxation and scan.
    rd_idx  = cmd.scan ? sj : item.to_node;
    cost_rd = cur_cost[rd_idx];

    prev_ext = (CW+1)'(prev_cost[item.from_node]);
    ec_ext   = (CW+1)'($signed(item.edge_cost));
    sum      = prev_ext + ec_ext;
    if (sum[CW] != sum[CW-1]) cand = sum[CW] ? COST_MIN : COST_MAX;
    else cand = sum[CW-1:0];

    edge_ok = (stage_total >= CNT_W'(2))
           && ({1'b0, item.from_node} < prev_size)
           && ({1'b0, item.to_node} < cur_size)
           && prev_reached[item.from_node];
    // Equal cost keeps the smaller source node.
    relax_we = cmd.relax && edge_ok
            && (!cur_reached[item.to_node] || (cand < cost_rd)
                || ((cand == cost_rd) && (item.from_node < cur_parent[item.to_node])));
    cur_stage = STAGE_W'(stage_total - CNT_W'(1));

    scan_hit = (stage_total != '0) && cur_reached[sj] && (!found || (cost_rd < best_cost));

    emit_last = !found || ({1'b0, ej} == (sol_n - CNT_W'(1)));

    pw_we   = cmd.pick || cmd.bt_write;
    pw_idx  = cmd.pick ? STAGE_W'(sol_n - CNT_W'(1)) : (bs - 1'b1);
    pw_data = cmd.pick ? best_node : rd_data;

    stat.scan_last = (stage_total == '0) || ({1'b0, sj} == (cur_size - CNT_W'(1)));
    stat.found     = found;
    stat.single    = (sol_n == CNT_W'(1));
    stat.bt_last   = (bs == STAGE_W'(1));
    stat.emit_last = emit_last;
    stat.out_free  = !out_valid || out_ready;
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_total  <= '0;
      prev_reached <= '0;
      cur_reached  <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (cmd.decl && decl_ok) begin
        prev_reached <= cur_reached;
        for (int j = 0; j < MAX_NODES; j++) begin
          cur_reached[j] <= (stage_total == '0) && (CNT_W'(j) < n_sat);
        end
        stage_total <= stage_total + 1'b1;
      end
      if (relax_we) cur_reached[item.to_node] <= 1'b1;
      // The problem is closed once the solve has chosen its end node.
      if (cmd.pick) begin
        stage_total  <= '0;
        prev_reached <= '0;
        cur_reached  <= '0;
      end
      if (cmd.emit) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  // Payload and working registers.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item  <= in_data;
      sj    <= '0;
      found <= 1'b0;
      ej    <= '0;
      sol_n <= stage_total;
    end
    if (cmd.decl && decl_ok) begin
      prev_cost <= cur_cost;
      for (int j = 0; j < MAX_NODES; j++) begin
        cur_cost[j] <= '0;
      end
      prev_size <= cur_size;
      cur_size  <= n_sat;
    end
    if (relax_we) begin
      cur_cost[item.to_node]   <= cand;
      cur_parent[item.to_node] <= item.from_node;
    end
    if (cmd.scan) begin
      if (scan_hit) begin
        found     <= 1'b1;
        best_cost <= cost_rd;
        best_node <= sj;
      end
      sj <= sj + 1'b1;
    end
    if (cmd.pick) begin
      bs       <= STAGE_W'(sol_n - CNT_W'(1));
      cur_node <= best_node;
    end
    if (cmd.bt_write) begin
      cur_node <= rd_data;
      bs       <= bs - 1'b1;
    end
    if (pw_we) path_buf[pw_idx] <= pw_data;
    if (cmd.emit) begin
      ej                   <= ej + 1'b1;
      out_data.stage_index <= found ? ej : '0;
      out_data.path_node   <= found ? path_buf[ej] : '0;
      out_data.total_cost  <= (found && emit_last) ? TOTAL_W'(best_cost) : '0;
      out_data.no_path     <= !found;
      out_data.last        <= emit_last;
    end
  end

  // Parent RAM, one row per stage, registered read for backtracking.
  always_ff @(posedge clk) begin
    if (relax_we) parent_mem[{cur_stage, item.to_node}] <= item.from_node;
    if (cmd.bt_read) rd_data <= parent_mem[{bs, cur_node}];
  end

endmodule

`default_nettype wire

### src/multistage_graph_shortest_path.sv
// Multistage-graph shortest path by dynamic programming. Requests declare a
// new stage, relax one edge from the previous stage into the newest stage,
// or ask for the solution. A declaration or an edge is taken in the idle
// state and then updates the cost tables in its own state (an edge is one
// saturating add and compare against the target's best cost). A solve scans
// the last stage one node per cycle, then chooses the end node, walks the
// parent RAM back through a read state and a write-back state per stage
// (one RAM read per step) and then loads one result per cycle into the
// output register while it is free, N results for N stages, or a single
// no-path result. A new request is taken as soon as the last result is in
// the output register, even before it is taken downstream.
// Depends on msgsp_pkg, msgsp_ctrl and msgsp_datapath.
`default_nettype none

module multistage_graph_shortest_path #(
  parameter int COST_WIDTH = msgsp_pkg::COST_WIDTH_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  msgsp_pkg::in_t  in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output msgsp_pkg::out_t out_data
);
  import msgsp_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  msgsp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_req   (in_data.req_type),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  msgsp_datapath #(
    .COST_WIDTH (COST_WIDTH)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

### src/msgsp_checker.sv
// Port-level checker for the multistage-graph shortest-path block, with the
// bind that attaches it to the top level. Depends on msgsp_pkg.
`default_nettype none

module msgsp_checker (
  input logic            clk,
  input logic            rst,
  input logic            in_valid,
  input logic            in_ready,
  input msgsp_pkg::in_t  in_data,
  input logic            out_valid,
  input logic            out_ready,
  input msgsp_pkg::out_t out_data
);

  // A stalled result must hold.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // A stalled request must hold.
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_ready |=> in_valid && $stable(in_data))
    else $error("request changed while stalled");

  // A no-path result stands alone and carries only zeros.
  a_no_path: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.no_path |->
      out_data.last && (out_data.stage_index == '0) && (out_data.path_node == '0)
      && (out_data.total_cost == '0))
    else $error("malformed no-path result");

  // Only the final result of a run carries the total or the no-path flag.
  a_mid_path: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.last |-> (out_data.total_cost == '0) && !out_data.no_path)
    else $error("intermediate result carries a total or no-path flag");

endmodule

bind multistage_graph_shortest_path msgsp_checker u_msgsp_checker (.*);

`default_nettype wire

### verif/tb.sv
// Self-checking testbench for the multistage-graph shortest-path block.
// Keeps its own copy of the stage tables, predicts every path hop and checks
// each one as it leaves the block. Depends on msgsp_pkg and the top module.
`timescale 1ns / 1ps

module tb;
  import msgsp_pkg::*;

  // Request code 3 has no meaning; the block must swallow it.
  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam longint COST_HI = (longint'(1) <<< (COST_WIDTH_DEF - 1)) - 1;
  localparam longint COST_LO = -COST_HI - 1;
  localparam int RANDOM_REQS = 420;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_ready;
  in_t  in_data;
  logic out_valid;
  logic out_ready;
  out_t out_data;

  // Shadow copy of the block's dynamic-programming state.
  int unsigned       dp_stages;
  int unsigned       dp_size [MAX_STAGES];
  longint            dp_prev_cost [MAX_NODES];
  longint            dp_cur_cost [MAX_NODES];
  bit                dp_prev_hit [MAX_NODES];
  bit                dp_cur_hit [MAX_NODES];
  logic [NODE_W-1:0] dp_parent [MAX_STAGES*MAX_NODES];

  out_t hop_q [$];
  int   fail_count;
  int   random_reqs;
  int   solves_sent;
  int   hops_seen;
  int   no_path_seen;
  bit   in_calm;
  bit   out_calm;

  multistage_graph_shortest_path dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #40ms;
    $display("%0t: timeout with %0d hops still pending", $time, hop_q.size());
    $display("status: fail");
    $finish;
  end

  // Appends one expected hop to the tail of the queue.
  function automatic void queue_hop(out_t o);
    hop_q = {hop_q, o};
  endfunction

  // Applies one accepted request to the shadow state and queues the path
  // hops that a solve produces.
  function automatic void dp_update(in_t r);
    int unsigned n, f, t, s, j, best, last_n;
    int unsigned path [MAX_STAGES];
    longint c, total;
    bit found;
    out_t o;
    case (r.req_type)
      REQ_DECL: begin
        n = r.node_count;
        if (n != 0 && dp_stages < MAX_STAGES) begin
          if (n > MAX_NODES) n = MAX_NODES;
          for (j = 0; j < MAX_NODES; j++) begin
            dp_prev_cost[j] = dp_cur_cost[j];
            dp_prev_hit[j]  = dp_cur_hit[j];
            dp_cur_cost[j]  = 0;
            dp_cur_hit[j]   = (dp_stages == 0) && (j < n);
          end
          dp_size[dp_stages] = n;
          dp_stages++;
        end
      end
      REQ_EDGE: begin
        f = r.from_node;
        t = r.to_node;
        if (dp_stages >= 2) begin
          s = dp_stages - 1;
          if (f < dp_size[s-1] && t < dp_size[s] && dp_prev_hit[f]) begin
            c = dp_prev_cost[f] + longint'(r.edge_cost);
            if (c > COST_HI) c = COST_HI;
            if (c < COST_LO) c = COST_LO;
            if (!dp_cur_hit[t] || c < dp_cur_cost[t] ||
                (c == dp_cur_cost[t] && f < dp_parent[s*MAX_NODES+t])) begin
              dp_cur_cost[t] = c;
              dp_cur_hit[t]  = 1'b1;
              dp_parent[s*MAX_NODES+t] = NODE_W'(f);
            end
          end
        end
      end
      REQ_SOLVE: begin
        solves_sent++;
        last_n = dp_stages;
        found  = 1'b0;
        total  = 0;
        best   = 0;
        if (last_n > 0) begin
          for (j = 0; j < dp_size[last_n-1]; j++) begin
            if (dp_cur_hit[j] && (!found || dp_cur_cost[j] < total)) begin
              found = 1'b1;
              total = dp_cur_cost[j];
              best  = j;
            end
          end
        end
        dp_stages = 0;
        for (j = 0; j < MAX_NODES; j++) begin
          dp_prev_hit[j] = 1'b0;
          dp_cur_hit[j]  = 1'b0;
        end
        if (!found) begin
          o = '0;
          o.no_path = 1'b1;
          o.last    = 1'b1;
          queue_hop(o);
        end else begin
          path[last_n-1] = best;
          for (s = last_n - 1; s > 0; s--) path[s-1] = dp_parent[s*MAX_NODES+path[s]];
          for (j = 0; j < last_n; j++) begin
            o.stage_index = STAGE_W'(j);
            o.path_node   = NODE_W'(path[j]);
            o.total_cost  = (j == last_n - 1) ? TOTAL_W'(total) : '0;
            o.no_path     = 1'b0;
            o.last        = (j == last_n - 1);
            queue_hop(o);
          end
        end
      end
      default: ;
    endcase
  endfunction

  function automatic in_t make_req(logic [1:0] kind, int count, int src, int dst, int cost);
    in_t r;
    r.req_type   = kind;
    r.node_count = CNT_W'(count);
    r.from_node  = NODE_W'(src);
    r.to_node    = NODE_W'(dst);
    r.edge_cost  = EDGE_W'(cost);
    return r;
  endfunction

  function automatic int pick_gap();
    int roll;
    if (in_calm) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 65) return 0;
    if (roll < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Mostly legal node indexes, now and then anything the field can hold.
  function automatic int pick_index(int size);
    if ($urandom_range(0, 9) == 0) return $urandom_range(0, 15);
    return $urandom_range(0, size - 1);
  endfunction

  // Small costs make ties common; the extremes exercise the full width.
  function automatic int pick_cost();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 40) return $urandom_range(0, 8) - 4;
    if (roll < 50) return -32768;
    if (roll < 60) return 32767;
    return $urandom_range(0, 65535);
  endfunction

  // Presents one request and returns at the edge where it is accepted.
  // Valid is left high so that a back-to-back request needs no second drive.
  task automatic send_req(in_t r);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= r;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    dp_update(r);
  endtask

  task automatic check_field(string name, logic signed [TOTAL_W-1:0] want,
                             logic signed [TOTAL_W-1:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin : result_check
    out_t want;
    if (!rst && out_valid && out_ready) begin
      if (hop_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, got %p", $time, out_data);
        fail_count++;
      end else begin
        want = hop_q.pop_front();
        check_field("stage_index", want.stage_index, out_data.stage_index);
        check_field("path_node", want.path_node, out_data.path_node);
        check_field("total_cost", want.total_cost, out_data.total_cost);
        check_field("no_path", want.no_path, out_data.no_path);
        check_field("last", want.last, out_data.last);
        hops_seen++;
        if (want.no_path) no_path_seen++;
      end
    end
  end

  // Downstream stalls: mostly short, some long, with calm stretches.
  initial begin : out_stall
    int left, roll;
    out_ready = 1'b0;
    out_calm  = 1'b0;
    left      = 0;
    forever begin
      @(posedge clk);
      if ($urandom_range(0, 255) == 0) out_calm = !out_calm;
      if (left > 0) begin
        out_ready <= 1'b0;
        left--;
      end else begin
        out_ready <= 1'b1;
        roll = $urandom_range(0, 99);
        if (!out_calm) begin
          if (roll < 15) left = $urandom_range(1, 3);
          else if (roll < 18) left = $urandom_range(10, 40);
        end
      end
    end
  end

  // Solve with nothing declared, after an undefined request code.
  task automatic test_empty_solve();
    send_req(make_req(REQ_UNUSED, 31, 15, 15, -1));
    send_req(make_req(REQ_SOLVE, 0, 0, 0, 0));
  endtask

  // A zero count is ignored and an oversized count saturates; one stage
  // alone solves to node 0 at cost 0.
  task automatic test_single_stage();
    send_req(make_req(REQ_DECL, 0, 0, 0, 0));
    send_req(make_req(REQ_DECL, 31, 0, 0, 0));
    send_req(make_req(REQ_SOLVE, 0, 0, 0, 0));
  endtask

  // Dropped edges, cost extremes, source ties and last-stage node ties.
  task automatic test_ties_and_extremes();
    send_req(make_req(REQ_DECL, 2, 0, 0, 0));
    send_req(make_req(REQ_EDGE, 0, 0, 0, -32768));
    send_req(make_req(REQ_DECL, 16, 0, 0, 0));
    send_req(make_req(REQ_EDGE, 0, 15, 15, 0));
    send_req(make_req(REQ_EDGE, 0, 1, 15, 32767));
    send_req(make_req(REQ_EDGE, 0, 0, 15, 32767));
    send_req(make_req(REQ_EDGE, 0, 1, 3, -32768));
    send_req(make_req(REQ_EDGE, 0, 0, 3, -32767));
    send_req(make_req(REQ_EDGE, 0, 0, 2, -32768));
    send_req(make_req(REQ_EDGE, 0, 1, 2, -32768));
    send_req(make_req(REQ_SOLVE, 0, 0, 0, 0));
  endtask

  // Edges out of unreached nodes are ignored, and a graph whose last stage
  // is never reached gives a no-path result.
  task automatic test_unreached_sources();
    send_req(make_req(REQ_DECL, 4, 0, 0, 0));
    send_req(make_req(REQ_DECL, 4, 0, 0, 0));
    send_req(make_req(REQ_EDGE, 0, 3, 1, 5));
    send_req(make_req(REQ_DECL, 3, 0, 0, 0));
    send_req(make_req(REQ_EDGE, 0, 0, 0, 9));
    send_req(make_req(REQ_EDGE, 0, 1, 2, -7));
    send_req(make_req(REQ_SOLVE, 0, 0, 0, 0));
    send_req(make_req(REQ_DECL, 2, 0, 0, 0));
    send_req(make_req(REQ_DECL, 2, 0, 0, 0));
    send_req(make_req(REQ_SOLVE, 0, 0, 0, 0));
  endtask

  // Random graphs: mostly well-formed stage-by-stage problems, some deep
  // enough to pass the stage limit, with stray codes and skipped solves.
  task automatic test_random_graphs();
    int n_st, s, n_edges, roll, cnt, prv, cur, lim;
    while (random_reqs < RANDOM_REQS) begin
      in_calm = ($urandom_range(0, 3) == 0);
      roll = $urandom_range(0, 99);
      if (roll < 10) n_st = 1;
      else if (roll < 80) n_st = $urandom_range(2, 5);
      else if (roll < 92) n_st = $urandom_range(6, 12);
      else n_st = $urandom_range(15, 18);
      for (s = 0; s < n_st; s++) begin
        roll = $urandom_range(0, 99);
        if (roll < 3) cnt = 0;
        else if (n_st > 5) cnt = $urandom_range(1, 3);
        else if (roll < 70) cnt = $urandom_range(1, 4);
        else if (roll < 90) cnt = $urandom_range(5, 16);
        else cnt = $urandom_range(17, 31);
        send_req(make_req(REQ_DECL, cnt, $urandom_range(0, 15), $urandom_range(0, 15),
                          $urandom_range(0, 65535)));
        random_reqs++;
        if (s > 0) begin
          if (dp_stages >= 2) begin
            prv = dp_size[dp_stages-2];
            cur = dp_size[dp_stages-1];
          end else begin
            prv = 4;
            cur = 4;
          end
          lim = (prv * cur + 1 < 10) ? prv * cur + 1 : 10;
          n_edges = $urandom_range(1, lim);
          repeat (n_edges) begin
            send_req(make_req(REQ_EDGE, $urandom_range(0, 31), pick_index(prv),
                              pick_index(cur), pick_cost()));
            random_reqs++;
          end
        end
        if ($urandom_range(0, 19) == 0)
          send_req(make_req(REQ_UNUSED, $urandom_range(0, 31), $urandom_range(0, 15),
                            $urandom_range(0, 15), $urandom_range(0, 65535)));
      end
      if ($urandom_range(0, 19) != 0) begin
        send_req(make_req(REQ_SOLVE, $urandom_range(0, 31), $urandom_range(0, 15),
                          $urandom_range(0, 15), $urandom_range(0, 65535)));
        random_reqs++;
      end
    end
  endtask

  initial begin
    rst       = 1'b1;
    in_valid  = 1'b0;
    in_data   = '0;
    in_calm   = 1'b0;
    fail_count   = 0;
    random_reqs  = 0;
    solves_sent  = 0;
    hops_seen    = 0;
    no_path_seen = 0;
    dp_stages    = 0;
    for (int j = 0; j < MAX_NODES; j++) begin
      dp_prev_cost[j] = 0;
      dp_cur_cost[j]  = 0;
      dp_prev_hit[j]  = 1'b0;
      dp_cur_hit[j]   = 1'b0;
    end
    for (int j = 0; j < MAX_STAGES; j++) dp_size[j] = 0;
    for (int j = 0; j < MAX_STAGES * MAX_NODES; j++) dp_parent[j] = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_empty_solve();
    test_single_stage();
    test_ties_and_extremes();
    test_unreached_sources();
    test_random_graphs();
    in_valid <= 1'b0;

    while (hop_q.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);

    $display("Ran %0d random requests after the directed cases; %0d solves produced",
             random_reqs, solves_sent);
    $display("%0d path hops checked, %0d of them no-path results", hops_seen, no_path_seen);
    if (fail_count == 0 && hop_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
